### design/heap_sort_engine_macros.svh
// Assertion macros shared by the heap sort engine RTL.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of aclk, suspended while aresetn is low.
`define HSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset cycles included.
`define HSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define HSE_ASSERT(lbl, prop, msg)
`define HSE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### design/hse_pkg.sv
// Types, sizes and sequencer states of the heap sort engine.
`default_nettype none

package hse_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Store address, element count (0..CAPACITY) and child index widths.
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = ADDR_W + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } hse_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_res;
        logic                         last_res;
        logic                         dropped;
    } hse_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SU_RD,
        ST_SU_CMP,
        ST_SORT,
        ST_PO_RD0,
        ST_PO_RDL,
        ST_PO_SWAP,
        ST_SD_RDL,
        ST_SD_RDR,
        ST_SD_PICK,
        ST_SD_CMP,
        ST_EM_RD,
        ST_EM_OUT
    } hse_state_t;

endpackage

`default_nettype wire

### design/heap_sort_engine.sv
// Top level of the heap sort engine: sequencer, heap store and shared comparator.
//
// The block sorts a list of signed values into ascending order. Each input beat
// holds one element and is sifted up into a max-heap kept in a single-port-read,
// single-port-write store of CAPACITY entries; the input is not ready while this
// runs. The beat flagged last starts the in-place sort: after a setup state, each
// of the n-1 pops reads the root and the last live element, moves the old root to
// the end of the live region and sifts the hole down. Then the n results leave in
// ascending order, each read from the store before it is shown and held until
// m_ready takes it.
// The pace is set by the one store read port and the one comparator, which every
// sift step shares. Elements offered while the store is full are discarded and
// every result of that list carries dropped = 1. No clearing pass is needed
// after reset.
`default_nettype none
`include "heap_sort_engine_macros.svh"

module heap_sort_engine
    import hse_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire hse_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output hse_out_t      m_data
);

    hse_state_t state_reg, state_next;

    logic signed [DATA_WIDTH-1:0] item_reg, item_next;
    logic signed [DATA_WIDTH-1:0] best_reg, best_next;
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic        [ADDR_W-1:0]     best_idx_reg, best_idx_next;
    logic        [ADDR_W-1:0]     pos_reg, pos_next;
    logic        [ADDR_W-1:0]     emit_idx_reg, emit_idx_next;
    logic        [CNT_W-1:0]      fill_reg, fill_next;
    logic        [CNT_W-1:0]      live_reg, live_next;
    logic                         ovf_reg, ovf_next;
    logic                         last_reg, last_next;

    logic signed [DATA_WIDTH-1:0] heap_store_mem [CAPACITY];

    logic                         mem_we, mem_re;
    logic        [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;

    logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b;
    logic                         gt;

    logic [ADDR_W-1:0] parent_idx;
    logic [IDX_W-1:0]  kid_idx, kid_r_idx, live_ext;
    logic [CNT_W-1:0]  live_m1;
    logic              kid_in, right_in, fill_full, more_pops, emit_final, s_acc;

    // Index arithmetic of the heap walk.
    assign parent_idx = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign kid_idx    = {pos_reg, 1'b1};
    assign kid_r_idx  = kid_idx + IDX_W'(1);
    assign live_ext   = IDX_W'(live_reg);
    assign live_m1    = live_reg - CNT_W'(1);
    assign kid_in     = kid_idx < live_ext;
    assign right_in   = kid_r_idx < live_ext;
    assign fill_full  = fill_reg == CNT_W'(CAPACITY);
    assign more_pops  = live_reg > CNT_W'(1);
    assign emit_final = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == fill_reg;
    assign s_acc      = s_valid && s_ready;

    // The one shared signed comparator: cmp_a > cmp_b.
    assign gt = cmp_a > cmp_b;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!fill_full) begin
                        state_next = ST_SU_RD;
                    end else if (s_data.last) begin
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SU_RD: begin
                if (pos_reg == '0) begin
                    state_next = last_reg ? ST_SORT : ST_IDLE;
                end else begin
                    state_next = ST_SU_CMP;
                end
            end
            ST_SU_CMP: begin
                if (gt) begin
                    state_next = ST_SU_RD;
                end else begin
                    state_next = last_reg ? ST_SORT : ST_IDLE;
                end
            end
            ST_SORT: begin
                state_next = (fill_reg > CNT_W'(1)) ? ST_PO_RD0 : ST_EM_RD;
            end
            ST_PO_RD0:  state_next = ST_PO_RDL;
            ST_PO_RDL:  state_next = ST_PO_SWAP;
            ST_PO_SWAP: state_next = ST_SD_RDL;
            ST_SD_RDL: begin
                if (kid_in) begin
                    state_next = ST_SD_RDR;
                end else begin
                    state_next = more_pops ? ST_PO_RD0 : ST_EM_RD;
                end
            end
            ST_SD_RDR:  state_next = ST_SD_PICK;
            ST_SD_PICK: state_next = ST_SD_CMP;
            ST_SD_CMP: begin
                if (gt) begin
                    state_next = ST_SD_RDL;
                end else begin
                    state_next = more_pops ? ST_PO_RD0 : ST_EM_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_OUT;
            ST_EM_OUT: begin
                if (m_ready) begin
                    state_next = emit_final ? ST_IDLE : ST_EM_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshakes, store ports and comparator operands for each state.
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = item_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;
        cmp_a     = item_reg;
        cmp_b     = rd_data_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SU_RD: begin
                if (pos_reg == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_idx;
                end
            end
            ST_SU_CMP: begin
                // A smaller parent moves down into the hole.
                mem_we = 1'b1;
                if (gt) begin
                    mem_wdata = rd_data_reg;
                end
            end
            ST_PO_RD0: begin
                mem_re = 1'b1;
            end
            ST_PO_RDL: begin
                mem_re    = 1'b1;
                mem_raddr = live_m1[ADDR_W-1:0];
            end
            ST_PO_SWAP: begin
                // The old root goes to the end of the live region.
                mem_we    = 1'b1;
                mem_waddr = live_m1[ADDR_W-1:0];
                mem_wdata = best_reg;
            end
            ST_SD_RDL: begin
                if (kid_in) begin
                    mem_re    = 1'b1;
                    mem_raddr = kid_idx[ADDR_W-1:0];
                end else begin
                    mem_we = 1'b1;
                end
            end
            ST_SD_RDR: begin
                mem_re    = 1'b1;
                mem_raddr = kid_r_idx[ADDR_W-1:0];
            end
            ST_SD_PICK: begin
                cmp_a = rd_data_reg;
                cmp_b = best_reg;
            end
            ST_SD_CMP: begin
                // A larger child moves up into the hole.
                cmp_a  = best_reg;
                cmp_b  = item_reg;
                mem_we = 1'b1;
                if (gt) begin
                    mem_wdata = best_reg;
                end
            end
            ST_EM_RD: begin
                mem_re    = 1'b1;
                mem_raddr = emit_idx_reg;
            end
            ST_EM_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Next values of the working registers.
    always_comb begin
        item_next     = item_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        pos_next      = pos_reg;
        emit_idx_next = emit_idx_reg;
        fill_next     = fill_reg;
        live_next     = live_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    item_next = s_data.value;
                    last_next = s_data.last;
                    if (fill_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        pos_next  = fill_reg[ADDR_W-1:0];
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_SU_CMP: begin
                if (gt) begin
                    pos_next = parent_idx;
                end
            end
            ST_SORT: begin
                live_next     = fill_reg;
                emit_idx_next = '0;
            end
            ST_PO_RDL: begin
                best_next = rd_data_reg;
            end
            ST_PO_SWAP: begin
                item_next = rd_data_reg;
                live_next = live_m1;
                pos_next  = '0;
            end
            ST_SD_RDR: begin
                best_next     = rd_data_reg;
                best_idx_next = kid_idx[ADDR_W-1:0];
            end
            ST_SD_PICK: begin
                if (right_in && gt) begin
                    best_next     = rd_data_reg;
                    best_idx_next = kid_r_idx[ADDR_W-1:0];
                end
            end
            ST_SD_CMP: begin
                if (gt) begin
                    pos_next = best_idx_reg;
                end
            end
            ST_EM_OUT: begin
                if (m_ready) begin
                    if (emit_final) begin
                        fill_next = '0;
                        ovf_next  = 1'b0;
                    end else begin
                        emit_idx_next = emit_idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                item_next = item_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        pos_reg      <= pos_next;
        emit_idx_reg <= emit_idx_next;
        live_reg     <= live_next;
        last_reg     <= last_next;
    end

    // Heap store with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= heap_store_mem[mem_raddr];
        end
    end

    // Result beat.
    assign m_data.value_res = rd_data_reg;
    assign m_data.last_res  = emit_final;
    assign m_data.dropped   = ovf_reg;

    `HSE_ASSERT(a_fill_bound, fill_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `HSE_ASSERT_ALWAYS(a_one_side, !(s_ready && m_valid), "input ready while a result is shown")
    `HSE_ASSERT(a_emit_nonempty, m_valid |-> fill_reg != '0, "result shown from an empty store")
    `HSE_ASSERT(a_drop_flag, s_acc && fill_full |=> ovf_reg, "full-store beat not flagged")
    `HSE_ASSERT(a_write_range, mem_we |-> CNT_W'(mem_waddr) < fill_reg, "store write beyond fill")

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the heap sort engine: lists in, ascending beats out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hse_pkg::*;

    // The idle limit leaves ample margin for sorting a full store.
    localparam int IDLE_LIMIT     = 10000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 90;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 20;
    localparam int REPORT_MAX     = 10;
    localparam int NUM_ROWS       = 22;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

    typedef struct packed {
        elem_t value;
        logic  last;
        logic  typed;
        elem_t exp_value;
        logic  exp_last;
        logic  exp_dropped;
    } stim_row_t;

    localparam elem_t MAX_VAL = 32'sh7FFF_FFFF;
    localparam elem_t MIN_VAL = 32'sh8000_0000;

    // Single-element lists carry their result in the table; longer ones use the predictor.
    stim_row_t stim_rows [NUM_ROWS] = '{
        '{MAX_VAL, 1'b1, 1'b1, MAX_VAL, 1'b1, 1'b0},
        '{MIN_VAL, 1'b1, 1'b1, MIN_VAL, 1'b1, 1'b0},
        '{32'sd0,  1'b1, 1'b1, 32'sd0,  1'b1, 1'b0},
        '{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
        '{32'sd5,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{MAX_VAL, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{MIN_VAL, 1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd7,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd7,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{-32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd7,  1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd4,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd2,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd0,  1'b1, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd2,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd4,  1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
        '{32'sd5,  1'b1, 1'b0, 32'sd0, 1'b0, 1'b0}
    };

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hse_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hse_out_t m_data;

    heap_sort_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Elements of the list being collected, kept in ascending order.
    elem_t    sorted_list[$];
    bit       list_overflowed = 1'b0;
    hse_out_t sorted_beats[$];
    int       mismatches   = 0;
    int       results_seen = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Full-range values, a narrow band that gives many duplicates, and values near the ends.
    function automatic elem_t pick_value();
        case ($urandom_range(0, 3))
            0: return elem_t'($urandom_range(0, 16)) - 8;
            1: begin
                if ($urandom_range(0, 1)) return MAX_VAL - elem_t'($urandom_range(0, 3));
                return MIN_VAL + elem_t'($urandom_range(0, 3));
            end
            default: return elem_t'($urandom);
        endcase
    endfunction

    // Predictor: collect the list in order, drop beyond capacity, and on the last
    // element queue the whole list in ascending order, or the table result if typed.
    function automatic void take_element(hse_in_t beat, bit typed, hse_out_t typed_result);
        int       pos;
        int       k;
        hse_out_t res;
        if (sorted_list.size() < CAPACITY) begin
            pos = 0;
            while (pos < sorted_list.size() && sorted_list[pos] <= beat.value) pos++;
            sorted_list.insert(pos, beat.value);
        end else begin
            list_overflowed = 1'b1;
        end
        if (!beat.last) return;
        if (typed) begin
            sorted_beats.push_back(typed_result);
        end else begin
            for (k = 0; k < sorted_list.size(); k++) begin
                res.value_res = sorted_list[k];
                res.last_res  = (k == sorted_list.size() - 1);
                res.dropped   = list_overflowed;
                sorted_beats.push_back(res);
            end
        end
        sorted_list.delete();
        list_overflowed = 1'b0;
    endfunction

    // Offer one beat after a random gap and hold it until the block takes it.
    task automatic send_beat(hse_in_t beat, bit typed, hse_out_t typed_result);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        take_element(beat, typed, typed_result);
    endtask

    // Stimulus: directed table, then random lists with one that overruns the store.
    initial begin
        hse_in_t  beat;
        hse_out_t typed_result;
        int       sent;
        int       list_no;
        int       list_len;
        int       k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            beat.value             = stim_rows[i].value;
            beat.last              = stim_rows[i].last;
            typed_result.value_res = stim_rows[i].exp_value;
            typed_result.last_res  = stim_rows[i].exp_last;
            typed_result.dropped   = stim_rows[i].exp_dropped;
            send_beat(beat, stim_rows[i].typed, typed_result);
        end

        sent    = 0;
        list_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (list_no == 1) begin
                list_len = $urandom_range(CAPACITY + 1, CAPACITY + 3);
            end else begin
                list_len = $urandom_range(1, 10);
            end
            for (k = 0; k < list_len; k++) begin
                beat.value = pick_value();
                beat.last  = (k == list_len - 1);
                send_beat(beat, 1'b0, '0);
            end
            sent += list_len;
            list_no++;
        end
        s_valid <= 1'b0;

        while (sorted_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && sorted_beats.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Result side: check each beat against the oldest expectation, then pick m_ready.
    initial begin
        int       hold_left;
        bit       held_once;
        hse_out_t want;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                results_seen++;
                if (sorted_beats.size() == 0) begin
                    flag_error($sformatf("unexpected beat: value %0d last %0b dropped %0b",
                                         m_data.value_res, m_data.last_res, m_data.dropped));
                end else begin
                    want = sorted_beats.pop_front();
                    if (m_data.value_res !== want.value_res ||
                        m_data.last_res  !== want.last_res  ||
                        m_data.dropped   !== want.dropped) begin
                        flag_error($sformatf(
                            "beat %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                            results_seen, want.value_res, want.last_res, want.dropped,
                            m_data.value_res, m_data.last_res, m_data.dropped));
                    end
                end
            end
            // One long back-pressure stretch while the sender keeps offering beats.
            if (!held_once && results_seen >= HOLD_AT_RESULT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule
